/* src/mva_pkg.sv */
// Shared constants and codes for the MIDI voice allocator.
package mva_pkg;

	localparam int CHANNELS = 8;
	localparam int SLOTS    = 8;
	localparam int NSLOTS   = CHANNELS * SLOTS;

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW = $clog2(SLOTS);
	localparam int AW = $clog2(NSLOTS);

	localparam int KEY_W  = 8;
	localparam int TICK_W = 32;
	localparam int ENTRY_W = KEY_W + TICK_W;

	localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
	localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
	localparam logic [1:0] MODE_ALL_OFF  = 2'd2;
	localparam logic [1:0] MODE_TICK     = 2'd3;

	localparam logic [1:0] KIND_PROGRAM  = 2'd0;
	localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
	localparam logic [1:0] KIND_NOTE_OFF = 2'd2;

	localparam logic [7:0] REG_VEL_FLOOR   = 8'd0;
	localparam logic [7:0] REG_VEL_CEILING = 8'd1;

	localparam logic [7:0] VEL_FLOOR_RESET   = 8'd0;
	localparam logic [7:0] VEL_CEILING_RESET = 8'd127;
	localparam logic [7:0] RELEASE_LOUDNESS  = 8'd100;

endpackage

/* src/mva_ram.sv */
// Generic single-port RAM with registered read.
module mva_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* src/midi_voice_allocator_unit.sv */
// Polyphonic MIDI voice allocator: sequencer, channel state, slot flags and slot RAM.
// Note on: steps through the match, free, slot and finish states.
// Note off, all off, tick: one slot per cycle through the slot RAM; note off ends early
// at its match. busy is high throughout.
// Each message is strobed for one cycle, one step after the next is found (the last in finish); no stall.
// arst_n clears all control state, slot flags, held counts, patches and time count.
module midi_voice_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [7:0]  instrument,
	input  logic [7:0]  key,
	input  logic [7:0]  velocity,
	input  logic [31:0] duration,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [2:0]  channel,
	output logic [7:0]  data_byte,
	output logic [7:0]  loudness,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import mva_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MATCH = 6'b000010,
		S_FREE  = 6'b000100,
		S_SLOT  = 6'b001000,
		S_SCAN  = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	typedef struct packed {
		logic [1:0]    kind;
		logic [CW-1:0] ch;
		logic [7:0]    data;
		logic [7:0]    loud;
	} msg_t;

	state_t state_q;

	logic [7:0]  vel_floor_q, vel_ceil_q;
	logic [31:0] time_count_q;
	logic [7:0]  patch_q [CHANNELS];
	logic [3:0]  held_q  [CHANNELS];
	logic [NSLOTS-1:0] down_q;

	logic [1:0]  mode_q;
	logic [7:0]  instr_q, key_q, vel_q;
	logic [31:0] dur_q;

	logic [CW-1:0] chan_q;
	logic [SW-1:0] sl_q;
	logic [AW-1:0] slot_idx_q;

	logic [AW:0]   scan_cnt_q;
	logic [CW-1:0] sc_ch_q;
	logic [SW-1:0] sc_sl_q;
	logic          v_s1;
	logic [AW-1:0] idx_s1;
	logic [CW-1:0] ch_s1;

	msg_t pend_q;
	logic pend_v_q;
	msg_t out_q;
	logic strobe_q, last_q;

	// shared read/write addresses into channel state and slot flags
	logic [CW-1:0] cidx;
	logic [AW-1:0] didx;
	logic [AW-1:0] ram_addr;
	logic          ram_we;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [7:0]  rd_key;
	logic [31:0] rd_end;
	logic [7:0]  patch_rd;
	logic [3:0]  held_rd;
	logic        down_rd;
	logic        scan_end, rel_hit;
	logic        push;
	msg_t        push_msg;
	logic [7:0]  vel_clamped;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign cidx     = (state_q == S_SCAN) ? ch_s1 : chan_q;
	assign didx     = (state_q == S_SCAN) ? idx_s1 : slot_idx_q;
	assign patch_rd = patch_q[cidx];
	assign held_rd  = held_q[cidx];
	assign down_rd  = down_q[didx];

	assign ram_addr  = (state_q == S_SCAN) ? scan_cnt_q[AW-1:0] : slot_idx_q;
	assign ram_we    = (state_q == S_SLOT) && !down_rd;
	assign ram_wdata = {key_q, time_count_q + dur_q};
	assign rd_key    = ram_rdata[ENTRY_W-1:TICK_W];
	assign rd_end    = ram_rdata[TICK_W-1:0];

	mva_ram #(.WIDTH(ENTRY_W), .DEPTH(NSLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign scan_end = (scan_cnt_q == (AW+1)'(NSLOTS));

	always_comb begin
		if (vel_q < vel_floor_q) begin
			vel_clamped = vel_floor_q;
		end else if (vel_q > vel_ceil_q) begin
			vel_clamped = vel_ceil_q;
		end else begin
			vel_clamped = vel_q;
		end
	end

	always_comb begin
		rel_hit = 1'b0;
		if (v_s1 && down_rd) begin
			case (mode_q)
				MODE_NOTE_OFF: rel_hit = (patch_rd == instr_q) && (rd_key == key_q);
				MODE_ALL_OFF:  rel_hit = 1'b1;
				MODE_TICK:     rel_hit = (rd_end != '0) && (time_count_q >= rd_end);
				default:       rel_hit = 1'b0;
			endcase
		end
	end

	always_comb begin
		push     = 1'b0;
		push_msg = '{kind: KIND_NOTE_OFF, ch: cidx, data: rd_key, loud: RELEASE_LOUDNESS};
		case (state_q)
			S_FREE: begin
				if (held_rd == '0) begin
					push     = 1'b1;
					push_msg = '{kind: KIND_PROGRAM, ch: chan_q, data: instr_q, loud: 8'd0};
				end
			end
			S_SLOT: begin
				if (!down_rd) begin
					push     = 1'b1;
					push_msg = '{kind: KIND_NOTE_ON, ch: chan_q, data: key_q, loud: vel_clamped};
				end
			end
			S_SCAN: begin
				push = rel_hit;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			vel_floor_q  <= VEL_FLOOR_RESET;
			vel_ceil_q   <= VEL_CEILING_RESET;
			time_count_q <= '0;
			down_q       <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				patch_q[c] <= '0;
				held_q[c]  <= '0;
			end
			pend_v_q   <= 1'b0;
			strobe_q   <= 1'b0;
			v_s1       <= 1'b0;
			scan_cnt_q <= '0;
			sc_ch_q    <= '0;
			sc_sl_q    <= '0;
			chan_q     <= '0;
			sl_q       <= '0;
			slot_idx_q <= '0;
		end else begin
			strobe_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_VEL_FLOOR) begin
					vel_floor_q <= cfg_data;
				end else if (cfg_index == REG_VEL_CEILING) begin
					vel_ceil_q <= cfg_data;
				end
			end

			// a found message waits in pend until the next one shows it was not the last
			if (push) begin
				pend_q   <= push_msg;
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_q    <= pend_q;
					last_q   <= 1'b0;
					strobe_q <= 1'b1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q  <= mode;
						instr_q <= instrument;
						key_q   <= key;
						vel_q   <= velocity;
						dur_q   <= duration;
						chan_q  <= '0;
						scan_cnt_q <= '0;
						sc_ch_q <= '0;
						sc_sl_q <= '0;
						v_s1    <= 1'b0;
						if (mode == MODE_NOTE_ON) begin
							state_q <= S_MATCH;
						end else begin
							if (mode == MODE_TICK) begin
								time_count_q <= time_count_q + 32'd1;
							end
							state_q <= S_SCAN;
						end
					end
				end
				S_MATCH: begin
					if (patch_rd == instr_q && held_rd < 4'(SLOTS - 1)) begin
						sl_q       <= '0;
						slot_idx_q <= AW'(32'(chan_q) * SLOTS);
						state_q    <= S_SLOT;
					end else if (chan_q == CW'(CHANNELS - 1)) begin
						chan_q  <= '0;
						state_q <= S_FREE;
					end else begin
						chan_q <= chan_q + 1'b1;
					end
				end
				S_FREE: begin
					if (held_rd == '0) begin
						patch_q[chan_q] <= instr_q;
						sl_q       <= '0;
						slot_idx_q <= AW'(32'(chan_q) * SLOTS);
						state_q    <= S_SLOT;
					end else if (chan_q == CW'(CHANNELS - 1)) begin
						state_q <= S_FIN;
					end else begin
						chan_q <= chan_q + 1'b1;
					end
				end
				S_SLOT: begin
					if (!down_rd) begin
						down_q[slot_idx_q] <= 1'b1;
						held_q[chan_q]     <= held_q[chan_q] + 4'd1;
						state_q            <= S_FIN;
					end else if (sl_q == SW'(SLOTS - 1)) begin
						state_q <= S_FIN;
					end else begin
						sl_q       <= sl_q + 1'b1;
						slot_idx_q <= slot_idx_q + 1'b1;
					end
				end
				S_SCAN: begin
					// read issue runs one slot ahead of the evaluation
					if (!scan_end) begin
						v_s1       <= 1'b1;
						idx_s1     <= scan_cnt_q[AW-1:0];
						ch_s1      <= sc_ch_q;
						scan_cnt_q <= scan_cnt_q + 1'b1;
						if (sc_sl_q == SW'(SLOTS - 1)) begin
							sc_sl_q <= '0;
							sc_ch_q <= sc_ch_q + 1'b1;
						end else begin
							sc_sl_q <= sc_sl_q + 1'b1;
						end
					end else begin
						v_s1 <= 1'b0;
					end
					if (rel_hit) begin
						down_q[idx_s1] <= 1'b0;
						held_q[ch_s1]  <= held_q[ch_s1] - 4'd1;
					end
					if ((rel_hit && mode_q == MODE_NOTE_OFF) || (scan_end && !v_s1)) begin
						v_s1    <= 1'b0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (pend_v_q) begin
						out_q    <= pend_q;
						last_q   <= 1'b1;
						strobe_q <= 1'b1;
						pend_v_q <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign strobe    = strobe_q;
	assign kind      = out_q.kind;
	assign channel   = 3'(out_q.ch);
	assign data_byte = out_q.data;
	assign loudness  = out_q.loud;
	assign last      = last_q;

endmodule
